@@ rtl/srpg_pkg.sv @@
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types, codes and the ramp table for the stepper ramp profile
// generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int STEP_W     = 24;
  localparam int PRESCALE_W = 12;
  localparam int POS_W      = 32;

  // straight-line ramp start and doubled drop, used when the ramp length is not the table depth
  localparam int RAMP_FIRST = 1777;
  localparam int RAMP_DROP  = 3494;
  localparam int ROM_DEPTH  = 150;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_PULSE   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic              move_up;
    logic              track_position;
    logic              return_after;
  } cmd_t;

  typedef struct packed {
    logic [PRESCALE_W-1:0]   period_prescale;
    logic                    running;
    logic                    dir_out;
    logic                    driver_enable;
    logic                    move_done;
    logic                    awaiting_release;
    logic signed [POS_W-1:0] position;
  } result_t;

  localparam logic [PRESCALE_W-1:0] RAMP_ROM [ROM_DEPTH] = '{
    12'd1777, 12'd1765, 12'd1754, 12'd1742, 12'd1730, 12'd1718, 12'd1707, 12'd1695,
    12'd1683, 12'd1671, 12'd1660, 12'd1648, 12'd1636, 12'd1625, 12'd1613, 12'd1601,
    12'd1589, 12'd1578, 12'd1566, 12'd1554, 12'd1543, 12'd1531, 12'd1519, 12'd1507,
    12'd1496, 12'd1484, 12'd1472, 12'd1460, 12'd1449, 12'd1437, 12'd1425, 12'd1414,
    12'd1402, 12'd1390, 12'd1378, 12'd1367, 12'd1355, 12'd1343, 12'd1331, 12'd1320,
    12'd1308, 12'd1296, 12'd1285, 12'd1273, 12'd1261, 12'd1249, 12'd1238, 12'd1226,
    12'd1214, 12'd1202, 12'd1191, 12'd1179, 12'd1167, 12'd1156, 12'd1144, 12'd1132,
    12'd1120, 12'd1109, 12'd1097, 12'd1085, 12'd1074, 12'd1062, 12'd1050, 12'd1038,
    12'd1027, 12'd1015, 12'd1003, 12'd991,  12'd980,  12'd968,  12'd956,  12'd945,
    12'd933,  12'd921,  12'd909,  12'd898,  12'd886,  12'd874,  12'd862,  12'd851,
    12'd839,  12'd827,  12'd816,  12'd804,  12'd792,  12'd780,  12'd769,  12'd757,
    12'd745,  12'd733,  12'd722,  12'd710,  12'd698,  12'd687,  12'd675,  12'd663,
    12'd651,  12'd640,  12'd628,  12'd616,  12'd605,  12'd593,  12'd581,  12'd569,
    12'd558,  12'd546,  12'd534,  12'd522,  12'd511,  12'd499,  12'd487,  12'd476,
    12'd464,  12'd452,  12'd440,  12'd429,  12'd417,  12'd405,  12'd393,  12'd382,
    12'd370,  12'd358,  12'd347,  12'd335,  12'd323,  12'd311,  12'd300,  12'd288,
    12'd276,  12'd265,  12'd253,  12'd241,  12'd229,  12'd218,  12'd206,  12'd194,
    12'd182,  12'd171,  12'd159,  12'd147,  12'd136,  12'd124,  12'd112,  12'd100,
    12'd89,   12'd77,   12'd65,   12'd53,   12'd42,   12'd30
  };

endpackage

@@ rtl/stepper_ramp_profile_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_ramp_profile_generator
// Trapezoidal step profile: start, pulse-done and release commands drive a
// mirrored ramp over a descending prescale table, with position tracking.
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// in_*      in   32+2   tuser: mode; tdata: step_count, move_up, track, return
// out_*     out  56     tdata: prescale, state flags, move_done, position
//
// one result per transfer, presented in the cycle after acceptance; a transfer every cycle while in_tready is high
// the state update and ramp table read complete in the accepting cycle
// synchronous active-low reset; ramp prescale resets to the first table entry
// in_tready drops only while a result is held and out_tready is low
// ----------------------------------------------------------------------------
module stepper_ramp_profile_generator #(
  parameter int RAMP_LEN = 150
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [23:0] step_count, [24] move_up, [25] track_position, [26] return_after
  input  logic [31:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] period_prescale, [12] running, [13] dir_out, [14] driver_enable,
  // [15] move_done, [16] awaiting_release, [48:17] position
  output logic [55:0] out_tdata
);

  srpg_pkg::cmd_t    cmd;
  srpg_pkg::result_t res;
  srpg_pkg::result_t res_q;
  logic              accept;

  assign cmd.step_count     = in_tdata[23:0];
  assign cmd.move_up        = in_tdata[24];
  assign cmd.track_position = in_tdata[25];
  assign cmd.return_after   = in_tdata[26];

  assign accept = in_tvalid && in_tready;

  srpg_ctrl #(
    .RAMP_LEN(RAMP_LEN)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .mode  (srpg_pkg::mode_t'(in_tuser)),
    .cmd   (cmd),
    .res   (res)
  );

  srpg_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_res   (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res_q)
  );

  assign out_tdata = {7'd0, res_q.position, res_q.awaiting_release, res_q.move_done,
                      res_q.driver_enable, res_q.dir_out, res_q.running,
                      res_q.period_prescale};

endmodule

@@ rtl/srpg_ramp_rom.sv @@
// ----------------------------------------------------------------------------
// srpg_ramp_rom
// Descending prescale ramp lookup, fixed table at the default length and a
// straight line from the first to the last prescale otherwise.
// ----------------------------------------------------------------------------
module srpg_ramp_rom #(
  parameter int RAMP_LEN = 150
) (
  input  logic [$clog2(RAMP_LEN)-1:0]         idx,
  output logic [srpg_pkg::PRESCALE_W-1:0]     value
);

  localparam int Span = RAMP_LEN - 1;

  generate
    if (RAMP_LEN == srpg_pkg::ROM_DEPTH) begin : g_fixed
      assign value = srpg_pkg::RAMP_ROM[idx];
    end else begin : g_line
      logic [srpg_pkg::PRESCALE_W-1:0] line_tbl [RAMP_LEN];
      for (genvar g = 0; g < RAMP_LEN; g++) begin : g_entry
        localparam int Drop = (srpg_pkg::RAMP_DROP * g + Span) / (2 * Span);
        assign line_tbl[g] = srpg_pkg::PRESCALE_W'(srpg_pkg::RAMP_FIRST - Drop);
      end
      assign value = line_tbl[idx];
    end
  endgenerate

endmodule

@@ rtl/srpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// srpg_ctrl
// Move state, pulse counting, ramp index selection and position tracking,
// updated once per accepted transfer.
// ----------------------------------------------------------------------------
module srpg_ctrl #(
  parameter int RAMP_LEN = 150
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  srpg_pkg::mode_t   mode,
  input  srpg_pkg::cmd_t    cmd,
  output srpg_pkg::result_t res
);

  localparam int IW = $clog2(RAMP_LEN);
  localparam int CW = $clog2(RAMP_LEN + 1);
  localparam int SW = srpg_pkg::STEP_W;
  localparam logic [srpg_pkg::PRESCALE_W-1:0] First =
    srpg_pkg::PRESCALE_W'(srpg_pkg::RAMP_FIRST);

  logic [SW-1:0]                   pd_r, pd_nxt;
  logic [SW-1:0]                   rem_r, rem_nxt;
  logic [SW-1:0]                   total_r, total_nxt;
  logic [CW-1:0]                   center_r, center_nxt;
  logic [srpg_pkg::PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic                            dir_r, dir_nxt;
  logic                            en_r, en_nxt;
  logic                            moving_r, moving_nxt;
  logic                            track_r, track_nxt;
  logic                            ret_r, ret_nxt;
  logic                            rw_r, rw_nxt;
  logic signed [srpg_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                            done;

  logic [SW-1:0]                   pd_inc;
  logic [SW-1:0]                   rem_dec;
  logic [SW-2:0]                   half;
  logic                            climb;
  logic [IW-1:0]                   rom_idx;
  logic [srpg_pkg::PRESCALE_W-1:0] rom_val;

  assign pd_inc  = pd_r + 1'b1;
  assign rem_dec = rem_r - 1'b1;
  assign half    = cmd.step_count[SW-1:1];
  assign climb   = pd_inc < SW'(center_r);
  assign rom_idx = climb ? pd_inc[IW-1:0] : rem_dec[IW-1:0];

  srpg_ramp_rom #(
    .RAMP_LEN(RAMP_LEN)
  ) u_rom (
    .idx  (rom_idx),
    .value(rom_val)
  );

  always_comb begin
    pd_nxt       = pd_r;
    rem_nxt      = rem_r;
    total_nxt    = total_r;
    center_nxt   = center_r;
    prescale_nxt = prescale_r;
    dir_nxt      = dir_r;
    en_nxt       = en_r;
    moving_nxt   = moving_r;
    track_nxt    = track_r;
    ret_nxt      = ret_r;
    rw_nxt       = rw_r;
    pos_nxt      = pos_r;
    done         = 1'b0;
    unique case (mode)
      srpg_pkg::MODE_START: begin
        if (!moving_r && !rw_r) begin
          total_nxt    = cmd.step_count;
          rem_nxt      = cmd.step_count;
          center_nxt   = ({1'b0, half} > SW'(RAMP_LEN)) ? CW'(RAMP_LEN) : half[CW-1:0];
          dir_nxt      = cmd.move_up;
          track_nxt    = cmd.track_position;
          ret_nxt      = cmd.return_after;
          en_nxt       = 1'b1;
          moving_nxt   = 1'b1;
          pd_nxt       = '0;
          prescale_nxt = First;
        end
      end
      srpg_pkg::MODE_PULSE: begin
        if (moving_r && !rw_r) begin
          if (track_r) begin
            pos_nxt = dir_r ? pos_r + 32'sd1 : pos_r - 32'sd1;
          end
          pd_nxt  = pd_inc;
          rem_nxt = rem_dec;
          if (climb) begin
            prescale_nxt = rom_val;
          end else if (rem_r != '0 && rem_dec < SW'(center_r)) begin
            prescale_nxt = rom_val;
          end
          if (rem_r <= SW'(1)) begin
            done         = 1'b1;
            prescale_nxt = First;
            pd_nxt       = '0;
            rem_nxt      = total_r;
            track_nxt    = 1'b0;
            dir_nxt      = 1'b0;
            en_nxt       = 1'b0;
            if (ret_r) begin
              ret_nxt = 1'b0;
              dir_nxt = 1'b1;
              en_nxt  = 1'b1;
              rw_nxt  = 1'b1;
            end else begin
              moving_nxt = 1'b0;
            end
          end
        end
      end
      srpg_pkg::MODE_RELEASE: begin
        if (rw_r) begin
          rw_nxt  = 1'b0;
          pd_nxt  = '0;
          rem_nxt = total_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r       <= '0;
      rem_r      <= '0;
      total_r    <= '0;
      center_r   <= '0;
      prescale_r <= First;
      dir_r      <= 1'b0;
      en_r       <= 1'b0;
      moving_r   <= 1'b0;
      track_r    <= 1'b0;
      ret_r      <= 1'b0;
      rw_r       <= 1'b0;
      pos_r      <= '0;
    end else if (accept) begin
      pd_r       <= pd_nxt;
      rem_r      <= rem_nxt;
      total_r    <= total_nxt;
      center_r   <= center_nxt;
      prescale_r <= prescale_nxt;
      dir_r      <= dir_nxt;
      en_r       <= en_nxt;
      moving_r   <= moving_nxt;
      track_r    <= track_nxt;
      ret_r      <= ret_nxt;
      rw_r       <= rw_nxt;
      pos_r      <= pos_nxt;
    end
  end

  assign res.period_prescale  = prescale_nxt;
  assign res.running          = moving_nxt;
  assign res.dir_out          = dir_nxt;
  assign res.driver_enable    = en_nxt;
  assign res.move_done        = done;
  assign res.awaiting_release = rw_nxt;
  assign res.position         = pos_nxt;

`ifndef SYNTH
  a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done) |=> (prescale_r == First && pd_r == '0 && !track_r))
    else $error("run end did not rewind the ramp");

  a_wait_implies_moving: assert property (@(posedge clk) disable iff (!rst_n)
    rw_r |-> (moving_r && dir_r && en_r && !ret_r))
    else $error("release wait outside a move");

  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (moving_r && !rw_r) |-> (SW'(pd_r + rem_r) == total_r))
    else $error("pulse count and remainder out of step");
`endif

endmodule

@@ rtl/srpg_out_reg.sv @@
// ----------------------------------------------------------------------------
// srpg_out_reg
// Result register with valid flag, decoupling the input handshake from a
// stalled result consumer.
// ----------------------------------------------------------------------------
module srpg_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srpg_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output srpg_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  srpg_pkg::result_t res_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= in_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ bench/tb_stepper_ramp_profile_generator.sv @@
// ----------------------------------------------------------------------------
// tb_stepper_ramp_profile_generator
// Self-checking bench for the stepper ramp profile generator. A short table of
// directed commands covers idle, ignored, zero-count, return and shortest-ramp
// cases; random move sequences with noise follow. Every result is checked field
// by field against an in-bench profile predictor or a directed row's expected
// result, with random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_profile_generator;

  localparam int RAMP_LEN       = 150;
  localparam int MOVE_BUDGET    = 1350;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_LEN       = 64;
  localparam int QUIET_FROM     = 700;
  localparam int QUIET_TO       = 1000;
  localparam int DIR_ROWS       = 21;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam srpg_pkg::result_t IDLE_RESULT =
    '{12'd1777, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0};

  typedef struct {
    logic [1:0]        mode;
    logic [23:0]       count;
    bit                up;
    bit                trk;
    bit                ret;
    bit                typed;
    srpg_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  stepper_ramp_profile_generator #(.RAMP_LEN(RAMP_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // profile predictor state
  logic [23:0] prof_done_cnt = '0;
  logic [23:0] prof_total = '0;
  logic [11:0] prof_prescale = 12'd1777;
  bit          prof_dir, prof_en, prof_moving, prof_tracking, prof_ret_pend, prof_rel_wait;
  logic [31:0] prof_pos = '0;

  srpg_pkg::result_t profile_q[$];
  int      errors = 0;
  int      results_seen = 0;
  int      cyc = 0;
  int      quiet_cycles = 0;
  int      moves_done = 0;

  function automatic logic [11:0] ramp_value(int unsigned i);
    int unsigned span;
    if (RAMP_LEN == srpg_pkg::ROM_DEPTH)
      return (i < srpg_pkg::ROM_DEPTH) ? srpg_pkg::RAMP_ROM[i]
                                       : srpg_pkg::RAMP_ROM[srpg_pkg::ROM_DEPTH-1];
    span = (RAMP_LEN > 1) ? RAMP_LEN - 1 : 1;
    if (i > span) i = span;
    return 12'(srpg_pkg::RAMP_FIRST - (srpg_pkg::RAMP_DROP * i + span) / (2 * span));
  endfunction

  function automatic bit advance_profile(logic [1:0] mode, logic [31:0] data,
                                         output srpg_pkg::result_t r);
    bit          acted;
    bit          done;
    int unsigned center;
    int unsigned back;
    acted = 1'b0;
    done  = 1'b0;
    if (mode == srpg_pkg::MODE_START) begin
      if (!prof_moving && !prof_rel_wait) begin
        acted         = 1'b1;
        prof_total    = data[23:0];
        prof_dir      = data[24];
        prof_tracking = data[25];
        prof_ret_pend = data[26];
        prof_en       = 1'b1;
        prof_moving   = 1'b1;
        prof_done_cnt = '0;
        prof_prescale = ramp_value(0);
      end
    end else if (mode == srpg_pkg::MODE_PULSE) begin
      if (prof_moving && !prof_rel_wait) begin
        acted = 1'b1;
        if (prof_tracking) prof_pos = prof_dir ? prof_pos + 1 : prof_pos - 1;
        prof_done_cnt = prof_done_cnt + 24'd1;
        center = prof_total / 2;
        if (center > RAMP_LEN) center = RAMP_LEN;
        if (prof_done_cnt < center) begin
          prof_prescale = ramp_value(prof_done_cnt);
        end else if (prof_done_cnt <= prof_total) begin
          back = prof_total - prof_done_cnt;
          if (back < center) prof_prescale = ramp_value(back);
        end
        if (prof_done_cnt >= prof_total) begin
          done          = 1'b1;
          prof_prescale = ramp_value(0);
          prof_done_cnt = '0;
          prof_tracking = 1'b0;
          prof_dir      = 1'b0;
          prof_en       = 1'b0;
          if (prof_ret_pend) begin
            prof_ret_pend = 1'b0;
            prof_dir      = 1'b1;
            prof_en       = 1'b1;
            prof_rel_wait = 1'b1;
          end else begin
            prof_moving = 1'b0;
          end
        end
      end
    end else if (mode == srpg_pkg::MODE_RELEASE) begin
      if (prof_rel_wait) begin
        acted         = 1'b1;
        prof_rel_wait = 1'b0;
        prof_done_cnt = '0;
      end
    end
    r.period_prescale  = prof_prescale;
    r.running          = prof_moving;
    r.dir_out          = prof_dir;
    r.driver_enable    = prof_en;
    r.move_done        = done;
    r.awaiting_release = prof_rel_wait;
    r.position         = prof_pos;
    return acted;
  endfunction

  task automatic offer(logic [1:0] mode, logic [31:0] data, bit typed,
                       srpg_pkg::result_t want);
    srpg_pkg::result_t r;
    bit                acted;
    if (!(cyc >= QUIET_FROM && cyc < QUIET_TO) && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    acted = advance_profile(mode, data, r);
    profile_q.push_back(typed ? want : r);
    moves_done += acted;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 50)
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    srpg_pkg::result_t got, exp;
    cyc <= cyc + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.period_prescale  = out_tdata[11:0];
      got.running          = out_tdata[12];
      got.dir_out          = out_tdata[13];
      got.driver_enable    = out_tdata[14];
      got.move_done        = out_tdata[15];
      got.awaiting_release = out_tdata[16];
      got.position         = out_tdata[48:17];
      if (profile_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], '0);
      end else begin
        exp = profile_q.pop_front();
        if (got.period_prescale != exp.period_prescale)
          report_mismatch("period_prescale", got.period_prescale, exp.period_prescale);
        if (got.running != exp.running)
          report_mismatch("running", got.running, exp.running);
        if (got.dir_out != exp.dir_out)
          report_mismatch("dir_out", got.dir_out, exp.dir_out);
        if (got.driver_enable != exp.driver_enable)
          report_mismatch("driver_enable", got.driver_enable, exp.driver_enable);
        if (got.move_done != exp.move_done)
          report_mismatch("move_done", got.move_done, exp.move_done);
        if (got.awaiting_release != exp.awaiting_release)
          report_mismatch("awaiting_release", got.awaiting_release, exp.awaiting_release);
        if (got.position != exp.position)
          report_mismatch("position", got.position, exp.position);
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no transfer on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_stepper_ramp_profile_generator failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (cyc >= QUIET_FROM && cyc < QUIET_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t   directed_rows [DIR_ROWS];
    logic [23:0] cnt;
    logic [1:0]  noise_mode;
    int          large_left;
    int          r;

    directed_rows = '{
      // pulse while idle, release while not waiting, unused mode
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b1, IDLE_RESULT},
      '{srpg_pkg::MODE_RELEASE, 24'd0,      1'b1, 1'b1, 1'b1, 1'b1, IDLE_RESULT},
      '{MODE_UNUSED,            24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, IDLE_RESULT},
      // zero count ends on the first pulse
      '{srpg_pkg::MODE_START,   24'd0,      1'b1, 1'b1, 1'b0, 1'b1,
        '{12'd1777, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'sd0}},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b1,
        '{12'd1777, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'sd1}},
      // tracked move down with return, start while running ignored
      '{srpg_pkg::MODE_START,   24'd3,      1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{srpg_pkg::MODE_START,   24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      // pulse and start while waiting for release are ignored
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_START,   24'hFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_RELEASE, 24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      // shortest ramps
      '{srpg_pkg::MODE_START,   24'd1,      1'b1, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_START,   24'd2,      1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{srpg_pkg::MODE_PULSE,   24'd0,      1'b0, 1'b0, 1'b0, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer(directed_rows[i].mode,
            {5'd0, directed_rows[i].ret, directed_rows[i].trk, directed_rows[i].up,
             directed_rows[i].count},
            directed_rows[i].typed, directed_rows[i].want);

    moves_done = 0;
    large_left = 2;
    while (moves_done < MOVE_BUDGET) begin
      r = $urandom_range(0, 99);
      if (!prof_moving && !prof_rel_wait) begin
        if (r < 8) begin
          noise_mode = 2'($urandom_range(1, 3));
          offer(noise_mode, {5'd0, 27'($urandom)}, 1'b0, '0);
        end else begin
          if ((large_left == 2 && moves_done > 300) ||
              (large_left == 1 && moves_done > 800)) begin
            cnt = 24'($urandom_range(301, 360));
            large_left--;
          end else if ($urandom_range(0, 9) < 7) begin
            cnt = 24'($urandom_range(0, 12));
          end else begin
            cnt = 24'($urandom_range(13, 80));
          end
          offer(srpg_pkg::MODE_START,
                {5'd0, 1'($urandom_range(0, 2) == 0), 2'($urandom), cnt}, 1'b0, '0);
        end
      end else if (prof_rel_wait) begin
        if (r < 10) begin
          noise_mode = $urandom_range(0, 1) ? srpg_pkg::MODE_PULSE : srpg_pkg::MODE_START;
          offer(noise_mode, {5'd0, 27'($urandom)}, 1'b0, '0);
        end else begin
          offer(srpg_pkg::MODE_RELEASE, {5'd0, 27'($urandom)}, 1'b0, '0);
        end
      end else begin
        if (r < 6) begin
          noise_mode = 2'($urandom_range(0, 1) ? srpg_pkg::MODE_START :
                          ($urandom_range(0, 1) ? srpg_pkg::MODE_RELEASE : MODE_UNUSED));
          offer(noise_mode, {5'd0, 27'($urandom)}, 1'b0, '0);
        end else begin
          offer(srpg_pkg::MODE_PULSE, {5'd0, 27'($urandom)}, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_stepper_ramp_profile_generator passed");
    end else begin
      $display("tb_stepper_ramp_profile_generator failed");
    end
    $finish;
  end

endmodule
